### rtl/multi_slot_countdown_scheduler_unit_assert.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk and rst_n in scope.
`ifndef MULTI_SLOT_COUNTDOWN_SCHEDULER_UNIT_ASSERT_SVH
`define MULTI_SLOT_COUNTDOWN_SCHEDULER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mscs_pkg.sv
package mscs_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_SLOTS_DEF   = 11;
  localparam int DELAY_WIDTH_DEF = 24;

  // Fixed field widths
  localparam int OPCODE_W = 2;
  localparam int SLOT_W   = 4;
  localparam int STEP_W   = 10;
  localparam int KIND_W   = 2;
  localparam int CLOCK_W  = 32;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_CHANGE = 2'd2,
    OP_CANCEL = 2'd3
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE    = 2'd0,
    EV_HANDLER = 2'd1,
    EV_PLAIN   = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef enum logic {
    MODE_ADD = 1'b0,
    MODE_SUB = 1'b1
  } alu_mode_t;

  // Status of the shared unit for a subtract pass
  typedef struct packed {
    logic active;
    logic expire;
  } alu_sts_t;

endpackage

### rtl/mscs_alu.sv
module mscs_alu #(
  parameter int CNT_W = mscs_pkg::DELAY_WIDTH_DEF + 1
) (
  input  mscs_pkg::alu_mode_t          mode,
  input  logic [CNT_W-1:0]             opa,
  input  logic [mscs_pkg::STEP_W-1:0]  step,
  output logic [CNT_W-1:0]             result,
  output mscs_pkg::alu_sts_t           sts
);

  localparam int OP_W = ((CNT_W > mscs_pkg::STEP_W) ? CNT_W : mscs_pkg::STEP_W) + 1;

  logic [OP_W-1:0] a_ext;
  logic [OP_W-1:0] b_ext;
  logic [OP_W-1:0] sum;
  logic            ovf;
  logic            borrow;

  assign a_ext = OP_W'(opa);
  assign b_ext = OP_W'(step);

  // One adder serves both the load sum and the per-slot decrement
  assign sum    = (mode == mscs_pkg::MODE_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
  assign borrow = sum[OP_W-1];
  assign ovf    = |sum[OP_W-1:CNT_W];

  // Saturate the load sum; pass the difference otherwise
  always_comb begin
    if (mode == mscs_pkg::MODE_ADD && ovf) begin
      result = {CNT_W{1'b1}};
    end else begin
      result = sum[CNT_W-1:0];
    end
  end

  // Expire when the count is nonzero and no larger than the step
  assign sts.active = |opa;
  assign sts.expire = (|opa) && (borrow || (sum == '0));

endmodule

### rtl/multi_slot_countdown_scheduler_unit.sv
// A tick walks every slot in ST_SCAN and gives its last result from ST_DONE;
// arm, change and cancel write the slot bank when accepted in ST_IDLE.
// Throughput: one item at a time; input stalls until a tick is done, with the
// single shared subtractor visiting one slot per cycle unless output stalls.
// Reset (rst_n low, synchronous): all slots, marks, reload value and clock clear,
// step returns to 1, and the output register empties.
`include "multi_slot_countdown_scheduler_unit_assert.svh"

module multi_slot_countdown_scheduler_unit #(
  parameter int NUM_SLOTS   = mscs_pkg::NUM_SLOTS_DEF,
  parameter int DELAY_WIDTH = mscs_pkg::DELAY_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration
  input  logic                              cfg_we,
  input  logic [mscs_pkg::STEP_W-1:0]       cfg_wdata,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mscs_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [mscs_pkg::SLOT_W-1:0]       in_slot,
  input  logic [DELAY_WIDTH-1:0]            in_delay_ms,
  input  logic                              in_with_handler,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mscs_pkg::KIND_W-1:0]       out_event_kind,
  output logic [mscs_pkg::SLOT_W-1:0]       out_slot_index,
  output logic                              out_clock_warning,
  output logic                              out_last
);

  localparam int CNT_W = DELAY_WIDTH + 1;
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMP_W = ((IDX_W > mscs_pkg::SLOT_W) ? IDX_W : mscs_pkg::SLOT_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  mscs_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]             rem_r [NUM_SLOTS];
  logic                         hnd_r [NUM_SLOTS];
  logic [CNT_W-1:0]             reload_r, reload_nxt;
  logic [mscs_pkg::CLOCK_W-1:0] clock_r, clock_nxt;
  logic [mscs_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         warn_r, warn_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;

  // Held expiry, waiting to learn whether another one follows
  logic                         pend_valid_r, pend_valid_nxt;
  mscs_pkg::event_kind_t        pend_kind_r, pend_kind_nxt;
  logic [IDX_W-1:0]             pend_idx_r, pend_idx_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [mscs_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [mscs_pkg::SLOT_W-1:0]  out_idx_r, out_idx_nxt;
  logic                         out_warn_r, out_warn_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         in_beat;
  logic                         out_busy;
  logic                         slot_ok;
  logic [IDX_W-1:0]             in_idx;
  logic [CNT_W-1:0]             rd_cnt;
  logic                         rd_hnd;

  mscs_pkg::alu_mode_t          alu_mode;
  logic [CNT_W-1:0]             alu_opa;
  logic [CNT_W-1:0]             alu_res;
  mscs_pkg::alu_sts_t           alu_sts;

  logic                         wr_en;
  logic [IDX_W-1:0]             wr_idx;
  logic [CNT_W-1:0]             wr_cnt;
  logic                         wr_hnd_en;
  logic                         wr_hnd;

  assign in_stall = (state_r != mscs_pkg::ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign slot_ok  = CMP_W'(in_slot) < CMP_W'(NUM_SLOTS);
  assign in_idx   = IDX_W'(in_slot);

  // Single read port into the slot bank
  assign rd_cnt = rem_r[idx_r];
  assign rd_hnd = hnd_r[idx_r];

  // Shared unit: load sum while idle, decrement while scanning
  assign alu_mode = (state_r == mscs_pkg::ST_SCAN) ? mscs_pkg::MODE_SUB : mscs_pkg::MODE_ADD;
  assign alu_opa  = (state_r == mscs_pkg::ST_SCAN) ? rd_cnt : CNT_W'(in_delay_ms);

  mscs_alu #(
    .CNT_W (CNT_W)
  ) u_alu (
    .mode   (alu_mode),
    .opa    (alu_opa),
    .step   (step_r),
    .result (alu_res),
    .sts    (alu_sts)
  );

  // Sequencer and bank write control
  always_comb begin
    state_nxt      = state_r;
    reload_nxt     = reload_r;
    clock_nxt      = clock_r;
    step_nxt       = cfg_we ? cfg_wdata : step_r;
    warn_nxt       = warn_r;
    idx_nxt        = idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_idx_nxt   = pend_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_idx_nxt    = out_idx_r;
    out_warn_nxt   = out_warn_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_idx         = idx_r;
    wr_cnt         = alu_res;
    wr_hnd_en      = 1'b0;
    wr_hnd         = 1'b0;

    unique case (state_r)
      mscs_pkg::ST_IDLE: begin
        if (in_beat) begin
          unique case (mscs_pkg::opcode_t'(in_opcode))
            mscs_pkg::OP_TICK: begin
              clock_nxt = clock_r + 1'b1;
              warn_nxt  = &clock_nxt[mscs_pkg::CLOCK_W-1:mscs_pkg::CLOCK_W/2];
              idx_nxt   = '0;
              state_nxt = mscs_pkg::ST_SCAN;
            end
            mscs_pkg::OP_ARM, mscs_pkg::OP_CHANGE: begin
              if (slot_ok) begin
                wr_en  = 1'b1;
                wr_idx = in_idx;
                wr_cnt = alu_res;
                if (in_idx == '0) begin
                  reload_nxt = alu_res;
                end
                if (in_opcode == mscs_pkg::OP_ARM) begin
                  wr_hnd_en = 1'b1;
                  wr_hnd    = in_with_handler;
                end
              end
            end
            mscs_pkg::OP_CANCEL: begin
              if (slot_ok) begin
                wr_en     = 1'b1;
                wr_idx    = in_idx;
                wr_cnt    = '0;
                wr_hnd_en = 1'b1;
                wr_hnd    = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      mscs_pkg::ST_SCAN: begin
        // Hold the walk if a second expiry finds the output still full
        if (!(alu_sts.expire && pend_valid_r && out_busy)) begin
          if (alu_sts.expire) begin
            wr_en     = 1'b1;
            wr_idx    = idx_r;
            wr_hnd_en = 1'b1;
            if (idx_r == '0) begin
              wr_cnt = reload_r;
              wr_hnd = rd_hnd;
            end else begin
              wr_cnt = '0;
              wr_hnd = 1'b0;
            end
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_idx_nxt   = mscs_pkg::SLOT_W'(pend_idx_r);
              out_warn_nxt  = warn_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_kind_nxt  = rd_hnd ? mscs_pkg::EV_HANDLER : mscs_pkg::EV_PLAIN;
            pend_idx_nxt   = idx_r;
          end else if (alu_sts.active) begin
            wr_en  = 1'b1;
            wr_idx = idx_r;
            wr_cnt = alu_res;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = mscs_pkg::ST_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      mscs_pkg::ST_DONE: begin
        // Drop the closing beat into the output once it is free
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_warn_nxt   = warn_r;
          out_last_nxt   = 1'b1;
          if (pend_valid_r) begin
            out_kind_nxt = pend_kind_r;
            out_idx_nxt  = mscs_pkg::SLOT_W'(pend_idx_r);
          end else begin
            out_kind_nxt = mscs_pkg::EV_NONE;
            out_idx_nxt  = '0;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = mscs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mscs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mscs_pkg::ST_IDLE;
      reload_r     <= '0;
      clock_r      <= '0;
      step_r       <= mscs_pkg::STEP_RESET;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      reload_r     <= reload_nxt;
      clock_r      <= clock_nxt;
      step_r       <= step_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    warn_r      <= warn_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_kind_r  <= out_kind_nxt;
    out_idx_r   <= out_idx_nxt;
    out_warn_r  <= out_warn_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Slot bank: counts and handler marks, one write per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        rem_r[i] <= '0;
        hnd_r[i] <= 1'b0;
      end
    end else begin
      if (wr_en) begin
        rem_r[wr_idx] <= wr_cnt;
      end
      if (wr_hnd_en) begin
        hnd_r[wr_idx] <= wr_hnd;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_slot_index    = out_idx_r;
  assign out_clock_warning = out_warn_r;
  assign out_last          = out_last_r;

  `MSCS_ASSERT_NEXT(a_tick_starts_scan, in_beat && (in_opcode == mscs_pkg::OP_TICK), state_r == mscs_pkg::ST_SCAN, "accepted tick did not start a slot walk")
  `MSCS_ASSERT_NOW(a_idx_in_range, state_r == mscs_pkg::ST_SCAN, idx_r <= LAST_IDX, "slot walk index beyond last slot")
  `MSCS_ASSERT_NOW(a_idle_no_pending, state_r == mscs_pkg::ST_IDLE, !pend_valid_r, "expiry left pending while idle")
  `MSCS_ASSERT_NEXT(a_done_emits_last, (state_r == mscs_pkg::ST_DONE) && !out_busy, out_valid_r && out_last_r, "closing beat of a tick not marked last")

endmodule

### sim/tb_multi_slot_countdown_scheduler_unit.sv
`timescale 1ns / 100ps

module tb_multi_slot_countdown_scheduler_unit;

  localparam int NUM_SLOTS   = mscs_pkg::NUM_SLOTS_DEF;
  localparam int DELAY_WIDTH = mscs_pkg::DELAY_WIDTH_DEF;
  localparam int CNT_W       = DELAY_WIDTH + 1;
  localparam int SLOT_W      = mscs_pkg::SLOT_W;
  localparam int STEP_W      = mscs_pkg::STEP_W;
  localparam int CLOCK_W     = mscs_pkg::CLOCK_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int QUIET_LIMIT = 4000;
  localparam int SEGMENTS    = 6;
  localparam int SEG_BEATS   = 22;

  // One result beat of a tick
  typedef struct packed {
    mscs_pkg::event_kind_t kind;
    logic [SLOT_W-1:0]     slot;
    logic                  warn;
    logic                  last;
  } tick_event_t;

  // Directed row: typed result only for single-result ticks that are obvious
  typedef struct packed {
    mscs_pkg::opcode_t      op;
    logic [SLOT_W-1:0]      slot;
    logic [DELAY_WIDTH-1:0] delay;
    logic                   hdl;
    logic                   typed;
    mscs_pkg::event_kind_t  kind;
    logic [SLOT_W-1:0]      idx;
  } dir_row_t;

  localparam int N_DIRECTED = 24;
  localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
    // nothing armed after reset
    '{mscs_pkg::OP_TICK,   4'd0,  24'd0,      1'b0, 1'b1, mscs_pkg::EV_NONE,    4'd0},
    // out-of-range arm is dropped
    '{mscs_pkg::OP_ARM,    4'd15, 24'hFFFFFF, 1'b1, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_TICK,   4'd15, 24'hFFFFFF, 1'b1, 1'b1, mscs_pkg::EV_NONE,    4'd0},
    // slot 0 with zero delay expires on the first tick
    '{mscs_pkg::OP_ARM,    4'd0,  24'd0,      1'b1, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_TICK,   4'd0,  24'd0,      1'b0, 1'b1, mscs_pkg::EV_HANDLER, 4'd0},
    '{mscs_pkg::OP_ARM,    4'd10, 24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_TICK,   4'd0,  24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    // cancel slot 0, reload value is kept
    '{mscs_pkg::OP_CANCEL, 4'd0,  24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_TICK,   4'd0,  24'd0,      1'b0, 1'b1, mscs_pkg::EV_NONE,    4'd0},
    // change keeps the handler mark
    '{mscs_pkg::OP_ARM,    4'd5,  24'hFFFFFF, 1'b1, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_CHANGE, 4'd5,  24'd2,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_CHANGE, 4'd0,  24'd1,      1'b1, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_TICK,   4'd0,  24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_TICK,   4'd0,  24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_TICK,   4'd0,  24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_CANCEL, 4'd15, 24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_CHANGE, 4'd12, 24'd5,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_ARM,    4'd7,  24'hAAAAAA, 1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_ARM,    4'd3,  24'h555555, 1'b1, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_TICK,   4'd0,  24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_CANCEL, 4'd7,  24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_CANCEL, 4'd3,  24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_CANCEL, 4'd0,  24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0},
    '{mscs_pkg::OP_TICK,   4'd0,  24'd0,      1'b0, 1'b0, mscs_pkg::EV_NONE,    4'd0}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [STEP_W-1:0]               cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [mscs_pkg::OPCODE_W-1:0]   in_opcode = '0;
  logic [SLOT_W-1:0]               in_slot = '0;
  logic [DELAY_WIDTH-1:0]          in_delay_ms = '0;
  logic                            in_with_handler = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [mscs_pkg::KIND_W-1:0]     out_event_kind;
  logic [SLOT_W-1:0]               out_slot_index;
  logic                            out_clock_warning;
  logic                            out_last;

  // Scheduler state as the testbench sees it
  logic [CNT_W-1:0]  slot_count [NUM_SLOTS];
  logic              slot_mark  [NUM_SLOTS];
  logic [CNT_W-1:0]  slot0_reload;
  logic [CLOCK_W-1:0] tick_count;
  logic [STEP_W-1:0] tick_step;

  tick_event_t fresh_events [$];
  tick_event_t pending_events [$];

  int sender_idle_pct   = 33;
  int receiver_idle_pct = 64;
  int mismatches        = 0;
  int beats_sent        = 0;
  int events_checked    = 0;
  int quiet_cycles      = 0;

  multi_slot_countdown_scheduler_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_slot          (in_slot),
    .in_delay_ms      (in_delay_ms),
    .in_with_handler  (in_with_handler),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_slot_index   (out_slot_index),
    .out_clock_warning(out_clock_warning),
    .out_last         (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Advance the scheduler state by one accepted beat; tick events go to fresh_events
  function automatic void schedule_beat(mscs_pkg::opcode_t op, logic [SLOT_W-1:0] slot,
                                        logic [DELAY_WIDTH-1:0] delay, logic hdl);
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] load;
    logic             warn;
    tick_event_t      ev;
    int               i;
    fresh_events.delete();
    if (op != mscs_pkg::OP_TICK) begin
      if (slot >= NUM_SLOTS) return;
      if (op == mscs_pkg::OP_CANCEL) begin
        slot_count[slot] = '0;
        slot_mark[slot]  = 1'b0;
        return;
      end
      // load delay plus one step, saturating at the counter width
      sum  = {2'b00, delay} + {{(CNT_W+1-STEP_W){1'b0}}, tick_step};
      load = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
      slot_count[slot] = load;
      if (slot == 0) slot0_reload = load;
      if (op == mscs_pkg::OP_ARM) slot_mark[slot] = hdl;
      return;
    end
    tick_count = tick_count + 1'b1;
    warn = (tick_count[CLOCK_W-1:16] == 16'hFFFF);
    // walk the slots in index order
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (slot_count[i] == '0) continue;
      if (slot_count[i] > tick_step) begin
        slot_count[i] = slot_count[i] - tick_step;
        continue;
      end
      ev.kind = slot_mark[i] ? mscs_pkg::EV_HANDLER : mscs_pkg::EV_PLAIN;
      ev.slot = SLOT_W'(i);
      ev.warn = warn;
      ev.last = 1'b0;
      fresh_events.push_back(ev);
      if (i == 0) begin
        slot_count[0] = slot0_reload;
      end else begin
        slot_count[i] = '0;
        slot_mark[i]  = 1'b0;
      end
    end
    if (fresh_events.size() == 0) begin
      ev.kind = mscs_pkg::EV_NONE;
      ev.slot = '0;
      ev.warn = warn;
      ev.last = 1'b0;
      fresh_events.push_back(ev);
    end
    fresh_events[fresh_events.size()-1].last = 1'b1;
  endfunction

  // Present one beat after a random gap, hold it until accepted, then predict
  task automatic send_beat(mscs_pkg::opcode_t op, logic [SLOT_W-1:0] slot,
                           logic [DELAY_WIDTH-1:0] delay, logic hdl,
                           logic typed, mscs_pkg::event_kind_t kind,
                           logic [SLOT_W-1:0] idx);
    int          gap;
    tick_event_t ev;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_slot         <= slot;
    in_delay_ms     <= delay;
    in_with_handler <= hdl;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    schedule_beat(op, slot, delay, hdl);
    if (typed) begin
      ev.kind = kind;
      ev.slot = idx;
      ev.warn = 1'b0;
      ev.last = 1'b1;
      pending_events.push_back(ev);
    end else begin
      foreach (fresh_events[k]) pending_events.push_back(fresh_events[k]);
    end
  endtask

  // Random beat: mostly in-range slots and delays that expire within a few ticks
  task automatic send_random_beat();
    int                     r;
    mscs_pkg::opcode_t      op;
    logic [SLOT_W-1:0]      slot;
    logic [DELAY_WIDTH-1:0] delay;
    r = $urandom_range(99);
    if (r < 45) op = mscs_pkg::OP_TICK;
    else if (r < 75) op = mscs_pkg::OP_ARM;
    else if (r < 87) op = mscs_pkg::OP_CHANGE;
    else op = mscs_pkg::OP_CANCEL;
    if ($urandom_range(99) < 90) slot = SLOT_W'($urandom_range(NUM_SLOTS-1));
    else slot = SLOT_W'($urandom_range(15, NUM_SLOTS));
    r = $urandom_range(99);
    if (r < 70) delay = DELAY_WIDTH'($urandom_range(3 * int'(tick_step) + 4));
    else if (r < 80) delay = '0;
    else if (r < 92) delay = DELAY_WIDTH'($urandom);
    else delay = '1;
    send_beat(op, slot, delay, 1'($urandom_range(1)), 1'b0, mscs_pkg::EV_NONE, '0);
  endtask

  // Hold the input until every pending event is back, then let the block settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_step(logic [STEP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tick_step = value;
  endtask

  function automatic void check_field(string field, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  // Compare each result beat with the oldest pending event
  always @(posedge clk) begin : result_check
    tick_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      events_checked++;
      if (pending_events.size() == 0) begin
        $error("result with nothing pending: event_kind %0d, slot_index %0d",
               out_event_kind, out_slot_index);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.kind, out_event_kind);
        check_field("slot_index", want.slot, out_slot_index);
        check_field("clock_warning", want.warn, out_clock_warning);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Stop the run if neither channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int                k;
    int                seg;
    logic [STEP_W-1:0] seg_step;
    for (k = 0; k < NUM_SLOTS; k++) begin
      slot_count[k] = '0;
      slot_mark[k]  = 1'b0;
    end
    slot0_reload = '0;
    tick_count   = '0;
    tick_step    = mscs_pkg::STEP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (k = 0; k < N_DIRECTED; k++) begin
      send_beat(DIRECTED[k].op, DIRECTED[k].slot, DIRECTED[k].delay, DIRECTED[k].hdl,
                DIRECTED[k].typed, DIRECTED[k].kind, DIRECTED[k].idx);
    end

    // Random segments, each under its own step
    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain_and_settle();
      if (seg == 2) begin
        sender_idle_pct   = 64;
        receiver_idle_pct = 33;
      end else if (seg == 4) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      case (seg)
        0:       seg_step = 10'd1000;
        1:       seg_step = 10'd0;
        2:       seg_step = 10'd1023;
        3:       seg_step = STEP_W'($urandom_range(2, 20));
        4:       seg_step = 10'd1;
        default: seg_step = STEP_W'($urandom_range(1, 1000));
      endcase
      write_step(seg_step);
      // arm every slot to expire together on one tick
      if (seg == 0 || seg == 4) begin
        for (k = 0; k < NUM_SLOTS; k++) begin
          send_beat(mscs_pkg::OP_ARM, SLOT_W'(k), '0, 1'($urandom_range(1)), 1'b0,
                    mscs_pkg::EV_NONE, '0);
        end
        send_beat(mscs_pkg::OP_TICK, '0, '0, 1'b0, 1'b0, mscs_pkg::EV_NONE, '0);
      end
      for (k = 0; k < SEG_BEATS; k++) send_random_beat();
    end

    drain_and_settle();
    $display("%0d input beats, %0d result beats checked; steps 0, 1, 1000, 1023 and random",
             beats_sent, events_checked);
    $display("all opcodes, out-of-range slots and full-bank expiry covered; clock stayed low");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### multi_slot_countdown_scheduler_unit.f
+incdir+rtl
rtl/mscs_pkg.sv
rtl/mscs_alu.sv
rtl/multi_slot_countdown_scheduler_unit.sv
sim/tb_multi_slot_countdown_scheduler_unit.sv
